/* design/b64e_pkg.sv */
// Package with the group command type, alphabet constants and the symbol lookup.
package b64e_pkg;

  // Index of the last symbol of a group (0..3), also the last character index.
  typedef logic [1:0] char_idx_t;

  // One group on its way from the byte gatherer to the character emitter.
  typedef struct packed {
    logic [23:0] group;      // three bytes, earliest in the high byte, zero-filled
    char_idx_t   sym_last;   // index of the last alphabet character
    char_idx_t   char_last;  // index of the last character, padding included
    logic        msg_end;    // group closes the message
    logic        url_safe;   // alphabet choice sampled at the emitting byte
  } cmd_t;

  localparam logic [7:0] PadChar     = 8'h3D;  // '='
  localparam logic [7:0] StdChar62   = 8'h2B;  // '+'
  localparam logic [7:0] StdChar63   = 8'h2F;  // '/'
  localparam logic [7:0] UrlChar62   = 8'h2D;  // '-'
  localparam logic [7:0] UrlChar63   = 8'h5F;  // '_'
  localparam logic [7:0] UpperBase   = 8'h41;  // 'A'
  localparam logic [7:0] LowerBase   = 8'h47;  // 'a' minus 26
  localparam logic [7:0] DigitOffset = 8'h04;  // 52 minus '0'
  localparam logic [5:0] SymFirstLow = 6'd26;
  localparam logic [5:0] SymFirstDig = 6'd52;
  localparam logic [5:0] Sym62       = 6'd62;
  localparam char_idx_t  FullLast    = 2'd3;

  // Maps a 6-bit symbol to its ASCII character.
  function automatic logic [7:0] sym_to_char(input logic [5:0] sym, input logic url_safe);
    logic [7:0] sym8;
    logic [7:0] ch;
    sym8 = {2'b00, sym};
    if (sym < SymFirstLow) begin
      ch = UpperBase + sym8;
    end else if (sym < SymFirstDig) begin
      ch = LowerBase + sym8;
    end else if (sym < Sym62) begin
      ch = sym8 - DigitOffset;
    end else if (sym == Sym62) begin
      ch = url_safe ? UrlChar62 : StdChar62;
    end else begin
      ch = url_safe ? UrlChar63 : StdChar63;
    end
    return ch;
  endfunction

endpackage

/* design/b64e_if.sv */
// Stream and configuration channel interfaces of the encoder.
interface b64e_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_message;
  modport source (output valid, output data_byte, output end_of_message, input ready);
  modport sink   (input valid, input data_byte, input end_of_message, output ready);
endinterface

interface b64e_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       end_of_text;
  modport source (output valid, output out_char, output end_of_text, input ready);
  modport sink   (input valid, input out_char, input end_of_text, output ready);
endinterface

interface b64e_cfg_if;
  logic valid;
  logic ready;
  logic url_safe_mode;
  modport source (output valid, output url_safe_mode, input ready);
  modport sink   (input valid, input url_safe_mode, output ready);
endinterface

/* design/base64_stream_encoder_top.sv */
// Top level of the streaming base64 encoder: gatherer, command queue and emitter.
//
//   Channel  Dir  Payload                      Item
//   in_if    in   data_byte, end_of_message    one message byte
//   out_if   out  out_char, end_of_text        one encoded character
//   cfg_if   in   url_safe_mode                mode register write
//
// The emitter produces one character per cycle from its output register while
// out_if is ready, so a full group of three bytes gives four characters and a
// closing group four or fewer. Bytes are taken one per cycle while the command
// queue has room; over a long message the emitter's one output port sets the pace.
// Reset clears the open group, the queue and the mode register (standard alphabet).
// A stalled output backs up the queue and then drops in_if.ready; the gatherer
// keeps taking bytes that only fill a group as long as the queue is not full.
module base64_stream_encoder_top #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  b64e_in_if.sink     in_if,
  b64e_cfg_if.sink    cfg_if,
  b64e_out_if.source  out_if
);

  // Group commands travel from the gatherer to the emitter through the queue.
  b64e_pkg::cmd_t push_cmd;
  b64e_pkg::cmd_t head_cmd;
  logic           q_push;
  logic           q_pop;
  logic           q_full;
  logic           q_empty;
  logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count;

  // The gatherer samples the mode at the byte that closes a group, so a
  // command in the queue keeps its alphabet even if the mode changes later.
  b64e_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (in_if),
    .cfg_if     (cfg_if),
    .q_full_i   (q_full),
    .cmd_push_o (q_push),
    .cmd_o      (push_cmd)
  );

  b64e_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (push_cmd),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .head_o      (head_cmd),
    .empty_o     (q_empty),
    .count_o     (q_count)
  );

  // The emitter walks the head command character by character and pops it
  // when its last character enters the output register.
  b64e_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (~q_empty),
    .cmd_i       (head_cmd),
    .cmd_pop_o   (q_pop),
    .out_if      (out_if)
  );

  // The gatherer never pushes into a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_push |-> !q_full)
    else $error("command pushed into a full queue");

  // The emitter never pops an empty queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop |-> !q_empty)
    else $error("command popped from an empty queue");

  // A push without a pop raises the fill level by exactly one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (q_push && !q_pop) |=> (q_count == $past(q_count) + 1'b1))
    else $error("queue count out of step with pushes");

endmodule

/* design/b64e_front.sv */
// Byte gatherer: holds the open group and the mode register, issues group commands.
module b64e_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  b64e_in_if.sink         in_if,
  b64e_cfg_if.sink        cfg_if,
  input  logic            q_full_i,
  output logic            cmd_push_o,
  output b64e_pkg::cmd_t  cmd_o
);

  logic [15:0] held_q, held_d;
  logic [1:0]  fill_q, fill_d;
  logic        mode_q;
  logic        accept;

  assign in_if.ready  = ~q_full_i;
  assign cfg_if.ready = 1'b1;
  assign accept       = in_if.valid & ~q_full_i;

  always_comb begin
    held_d           = held_q;
    fill_d           = fill_q;
    cmd_push_o       = 1'b0;
    cmd_o.group      = {held_q, in_if.data_byte};
    cmd_o.sym_last   = b64e_pkg::FullLast;
    cmd_o.char_last  = b64e_pkg::FullLast;
    cmd_o.msg_end    = in_if.end_of_message;
    cmd_o.url_safe   = mode_q;
    if (fill_q == 2'd2) begin
      cmd_push_o = accept;
    end else if (!in_if.end_of_message) begin
      if (accept) begin
        held_d = (fill_q == 2'd0) ? {8'h00, in_if.data_byte} : {held_q[7:0], in_if.data_byte};
        fill_d = fill_q + 2'd1;
      end
    end else if (fill_q == 2'd1) begin
      cmd_push_o      = accept;
      cmd_o.group     = {held_q[7:0], in_if.data_byte, 8'h00};
      cmd_o.sym_last  = 2'd2;
      cmd_o.char_last = mode_q ? 2'd2 : b64e_pkg::FullLast;
    end else begin
      cmd_push_o      = accept;
      cmd_o.group     = {in_if.data_byte, 16'h0000};
      cmd_o.sym_last  = 2'd1;
      cmd_o.char_last = mode_q ? 2'd1 : b64e_pkg::FullLast;
    end
    if (cmd_push_o) begin
      held_d = '0;
      fill_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
      fill_q <= '0;
      mode_q <= 1'b0;
    end else begin
      held_q <= held_d;
      fill_q <= fill_d;
      if (cfg_if.valid) begin
        mode_q <= cfg_if.url_safe_mode;
      end
    end
  end

endmodule

/* design/b64e_queue.sv */
// Small register queue of group commands between the gatherer and the emitter.
module b64e_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  b64e_pkg::cmd_t  push_data_i,
  output logic            full_o,
  input  logic            pop_i,
  output b64e_pkg::cmd_t  head_o,
  output logic            empty_o,
  output logic [$clog2(Depth+1)-1:0] count_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  b64e_pkg::cmd_t  mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];
  assign count_o = cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == LastPtr) ? '0 : wr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == LastPtr) ? '0 : rd_q + PtrW'(1);
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + CntW'(1);
        2'b01:   cnt_q <= cnt_q - CntW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

/* design/b64e_back.sv */
// Character emitter: turns one group command into characters, one per cycle while out_if is ready.
module b64e_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cmd_valid_i,
  input  b64e_pkg::cmd_t  cmd_i,
  output logic            cmd_pop_o,
  b64e_out_if.source      out_if
);

  b64e_pkg::char_idx_t k_q;
  logic                valid_q;
  logic [7:0]          char_q, char_d;
  logic                eot_q, eot_d;
  logic [5:0]          sym;
  logic                load;
  logic                at_last;

  assign load      = cmd_valid_i & (~valid_q | out_if.ready);
  assign at_last   = (k_q == cmd_i.char_last);
  assign cmd_pop_o = load & at_last;

  always_comb begin
    case (k_q)
      2'd0:    sym = cmd_i.group[23:18];
      2'd1:    sym = cmd_i.group[17:12];
      2'd2:    sym = cmd_i.group[11:6];
      default: sym = cmd_i.group[5:0];
    endcase
    char_d = (k_q <= cmd_i.sym_last) ? b64e_pkg::sym_to_char(sym, cmd_i.url_safe)
                                     : b64e_pkg::PadChar;
    eot_d  = cmd_i.msg_end & at_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      k_q     <= '0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        k_q     <= at_last ? '0 : k_q + 2'd1;
      end else if (out_if.ready) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      char_q <= char_d;
      eot_q  <= eot_d;
    end
  end

  assign out_if.valid       = valid_q;
  assign out_if.out_char    = char_q;
  assign out_if.end_of_text = eot_q;

endmodule
